FILE: rtl/itoa_pkg.sv
// shared types, constants and helpers for the radix ascii converter
package itoa_pkg;

    // default operand width
    localparam int unsigned VALUE_WIDTH_DEF = 64;
    // fixed field widths of the channels
    localparam int unsigned VALUE_FIELD_W = 64;
    localparam int unsigned BASE_W        = 6;
    localparam int unsigned CHAR_W        = 8;

    localparam logic [BASE_W-1:0] DEC_BASE = 6'd10;
    localparam logic [BASE_W-1:0] MIN_BASE = 6'd2;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    // input transfer payload
    typedef struct packed {
        logic [VALUE_FIELD_W-1:0] value;
        logic [BASE_W-1:0]        base;
        logic                     mode;
    } itoa_in_t;

    // output transfer payload
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } itoa_out_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_SIGN,
        ST_FETCH,
        ST_LOAD,
        ST_SEND
    } itoa_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic start;
        logic div_step;
        logic store;
        logic sign_load;
        logic fetch;
        logic out_load;
    } itoa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic q_zero;
        logic minus;
        logic cnt_zero;
    } itoa_stat_t;

    // digit value to its ascii character, letters from ten upward
    function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-BASE_W){1'b0}}, d};
        if (d < DEC_BASE) begin
            return CH_ZERO + dx;
        end else begin
            return CH_ALPHA + dx - {{(CHAR_W-BASE_W){1'b0}}, DEC_BASE};
        end
    endfunction

endpackage

FILE: rtl/integer_to_radix_ascii.sv
// top level: integer to ascii digits in a selectable radix
// Converts one VALUE_WIDTH-bit operand per input transfer into its ASCII
// digits, most significant first, one character per output transfer, with
// last set on the final one. A base of 0 or 1 means decimal; digits from ten
// up print as 'A', 'B', ... . In signed mode with base exactly 10 a negative
// operand prints '-' and then its magnitude. Each digit comes from the
// bit-serial restoring divider, one quotient bit a cycle, and is then
// stored in the digit memory; each character is fetched from the digit
// memory, loaded into the output register and presented until taken. One
// item is converted at a time; the next is accepted once the last character
// has been taken.
module integer_to_radix_ascii #(
    parameter int unsigned VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  itoa_pkg::itoa_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output itoa_pkg::itoa_out_t m_data
);
    import itoa_pkg::*;

    itoa_cmd_t  cmd;
    itoa_stat_t stat;

    // sequencing
    itoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // divider and digit buffer
    itoa_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_data)
    );

endmodule

FILE: rtl/itoa_dpath.sv
// datapath: restoring divider, digit memory, digit counter and output register
module itoa_dpath #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  itoa_pkg::itoa_in_t  in_data,
    input  itoa_pkg::itoa_cmd_t cmd,
    output itoa_pkg::itoa_stat_t stat,
    output itoa_pkg::itoa_out_t out_data
);
    import itoa_pkg::*;

    localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int unsigned ADDR_W = $clog2(VALUE_WIDTH);
    localparam int unsigned BIT_W  = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [BASE_W-1:0]      rem_reg, rem_next;
    logic [BASE_W-1:0]      radix_reg, radix_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   minus_reg, minus_next;
    itoa_out_t              out_reg, out_next;

    logic [BASE_W-1:0]      mem [VALUE_WIDTH];
    logic [BASE_W-1:0]      rd_data_reg;

    logic [VALUE_WIDTH-1:0] operand;
    logic                   neg_in;
    logic [BASE_W:0]        trial;
    logic                   trial_ge;
    logic [CNT_W-1:0]       cnt_dec;

    assign operand  = in_data.value[VALUE_WIDTH-1:0];
    assign neg_in   = (in_data.mode == MODE_SIGNED) && (in_data.base == DEC_BASE)
                      && operand[VALUE_WIDTH-1];
    // one restoring step: shift in next dividend bit, compare with radix
    assign trial    = {rem_reg, q_reg[VALUE_WIDTH-1]};
    assign trial_ge = trial >= {1'b0, radix_reg};
    assign cnt_dec  = cnt_reg - CNT_W'(1);

    // next values of datapath registers
    always_comb begin
        q_next     = q_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        minus_next = minus_reg;
        out_next   = out_reg;
        if (cmd.start) begin
            minus_next = neg_in;
            q_next     = neg_in ? (~operand + VALUE_WIDTH'(1)) : operand;
            radix_next = (in_data.base < MIN_BASE) ? DEC_BASE : in_data.base;
            rem_next   = '0;
            bit_next   = '0;
            cnt_next   = '0;
        end
        if (cmd.div_step) begin
            q_next   = {q_reg[VALUE_WIDTH-2:0], trial_ge};
            rem_next = trial_ge ? BASE_W'(trial - {1'b0, radix_reg}) : trial[BASE_W-1:0];
            bit_next = bit_reg + BIT_W'(1);
        end
        if (cmd.store) begin
            cnt_next = cnt_reg + CNT_W'(1);
            rem_next = '0;
            bit_next = '0;
        end
        if (cmd.fetch) begin
            cnt_next = cnt_dec;
        end
        if (cmd.sign_load) begin
            out_next.char_code = CH_MINUS;
            out_next.last      = 1'b0;
        end
        if (cmd.out_load) begin
            out_next.char_code = digit_char(rd_data_reg);
            out_next.last      = (cnt_reg == '0);
        end
    end

    // control-side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            minus_reg <= 1'b0;
            bit_reg   <= '0;
            rem_reg   <= '0;
            radix_reg <= DEC_BASE;
        end else begin
            cnt_reg   <= cnt_next;
            minus_reg <= minus_next;
            bit_reg   <= bit_next;
            rem_reg   <= rem_next;
            radix_reg <= radix_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        out_reg <= out_next;
    end

    // digit memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[cnt_reg[ADDR_W-1:0]] <= rem_reg;
        end
        if (cmd.fetch) begin
            rd_data_reg <= mem[cnt_dec[ADDR_W-1:0]];
        end
    end

    assign stat.div_last = (bit_reg == BIT_W'(VALUE_WIDTH - 1));
    assign stat.q_zero   = (q_reg == '0);
    assign stat.minus    = minus_reg;
    assign stat.cnt_zero = (cnt_reg == '0);
    assign out_data      = out_reg;

    // divider remainder stays below the radix
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < radix_reg)
        else $error("remainder not below radix");

    // each stored digit bumps the count by one
    a_store_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("digit count did not advance on store");

    // a digit loaded into the output is last exactly when no digits remain
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_reg.last == (cnt_reg == '0))
        else $error("last flag disagrees with digit count");

endmodule

FILE: rtl/itoa_ctrl.sv
// controller state machine sequencing divide, store and emit phases
module itoa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  itoa_pkg::itoa_stat_t stat,
    output itoa_pkg::itoa_cmd_t  cmd
);
    import itoa_pkg::*;

    itoa_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_last) state_next = ST_STORE;
            end
            ST_STORE: begin
                if (!stat.q_zero) begin
                    state_next = ST_DIV;
                end else if (stat.minus) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_SIGN:  state_next = ST_SEND;
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_SEND;
            ST_SEND: begin
                if (m_ready) state_next = stat.cnt_zero ? ST_IDLE : ST_FETCH;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            ST_DIV:   cmd.div_step  = 1'b1;
            ST_STORE: cmd.store     = 1'b1;
            ST_SIGN:  cmd.sign_load = 1'b1;
            ST_FETCH: cmd.fetch     = 1'b1;
            ST_LOAD:  cmd.out_load  = 1'b1;
            ST_SEND:  m_valid       = 1'b1;
            default: begin
                cmd = '0;
            end
        endcase
    end

    // an accepted item starts the division
    a_start_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_DIV)
        else $error("accepted item did not start division");

    // a pending character is held until taken
    a_send_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEND && !m_ready |=> state_reg == ST_SEND)
        else $error("pending character dropped");

    // the last divide step is always followed by a digit store
    a_div_store: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && stat.div_last |=> state_reg == ST_STORE)
        else $error("digit not stored after division");

endmodule
